FILE: rtl/gda_pkg.sv
// shared types, codes and calendar helpers for the gregorian date adder
`default_nettype none

package gda_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 15;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned AMOUNT_W = 10;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned ADDEND_W = 14;

    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 15'd32767;
    localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd12;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [ADDEND_W-1:0] ADD_CENTURY  = 14'd100;
    localparam logic [ADDEND_W-1:0] ADD_MILLENIA = 14'd1000;
    localparam logic [12:0]         RECIP_100    = 13'd5243;
    localparam int unsigned         RECIP_SHIFT  = 19;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DAYS       = 3'd0,
        FUNC_WEEKS      = 3'd1,
        FUNC_MONTHS     = 3'd2,
        FUNC_YEARS      = 3'd3,
        FUNC_DECADES    = 3'd4,
        FUNC_CENTURY    = 3'd5,
        FUNC_MILLENNIUM = 3'd6
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_CHECK,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_DAY,
        OP_MONTH,
        OP_YEARS
    } op_t;

    typedef struct packed {
        op_t  op;
        logic leap;
    } step_ctrl_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // y / 100 by reciprocal, exact over the whole 15-bit range
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [27:0]       prod;
        logic [8:0]        quot;
        logic [YEAR_W-1:0] hund;
        logic [YEAR_W-1:0] rem;
        prod = {13'd0, y} * {15'd0, RECIP_100};
        quot = prod[27:RECIP_SHIFT];
        hund = ({6'd0, quot} << 6) + ({6'd0, quot} << 5) + ({6'd0, quot} << 2);
        rem  = y - hund;
        if (rem == '0)
            return quot[1:0] == 2'b00;
        return y[1:0] == 2'b00;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gda_step.sv
// shared step unit: one day step, one month step or a saturating year add
`default_nettype none

module gda_step (
    input  wire gda_pkg::step_ctrl_t                ctrl,
    input  wire gda_pkg::date_t                     cur,
    input  wire logic [gda_pkg::ADDEND_W-1:0]       addend,
    output gda_pkg::date_t                          nxt,
    output logic                                    ovf
);

    logic [gda_pkg::DAY_W-1:0]  len_cur;
    logic [gda_pkg::DAY_W-1:0]  len_new;
    logic [gda_pkg::YEAR_W:0]   year_sum;
    gda_pkg::date_t             mon;

    always_comb
    begin
        len_cur  = gda_pkg::days_in(cur.month, ctrl.leap);
        year_sum = {1'b0, cur.year} + {2'b00, addend};
        mon      = cur;
        nxt      = cur;
        ovf      = 1'b0;
        len_new  = '0;
        case (ctrl.op)
            gda_pkg::OP_DAY:
            begin
                if (cur.day < len_cur)
                begin
                    nxt.day = cur.day + 5'd1;
                end
                else if (cur.month < gda_pkg::MONTH_DEC)
                begin
                    nxt.day   = 5'd1;
                    nxt.month = cur.month + 4'd1;
                end
                else if (cur.year < gda_pkg::YEAR_MAX)
                begin
                    nxt.day   = 5'd1;
                    nxt.month = 4'd1;
                    nxt.year  = cur.year + 15'd1;
                end
                else
                begin
                    ovf = 1'b1;
                end
            end
            gda_pkg::OP_MONTH:
            begin
                if (cur.month < gda_pkg::MONTH_DEC)
                begin
                    mon.month = cur.month + 4'd1;
                end
                else if (cur.year < gda_pkg::YEAR_MAX)
                begin
                    mon.month = 4'd1;
                    mon.year  = cur.year + 15'd1;
                end
                else
                begin
                    ovf = 1'b1;
                end
                // january after a year roll has no leap dependence
                len_new = gda_pkg::days_in(mon.month, ctrl.leap);
                nxt     = mon;
                if (!ovf && cur.day > len_new)
                begin
                    nxt.day = len_new;
                end
            end
            gda_pkg::OP_YEARS:
            begin
                if (year_sum > {1'b0, gda_pkg::YEAR_MAX})
                begin
                    nxt.year = gda_pkg::YEAR_MAX;
                    ovf      = 1'b1;
                end
                else
                begin
                    nxt.year = year_sum[gda_pkg::YEAR_W-1:0];
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_adder.sv
// top level of the gregorian date adder: handshake, sequencer and result register
//
// usage
//   input word on s_axis: tuser carries the operation code, tdata the count and
//   the starting date. result word on m_axis: tdata the date, tuser the flags.
//   one result word follows every input word, in order.
// sequencing
//   one input word at a time; s_axis_tready is high only while the sequencer
//   is idle. an accepted word passes the settle and check states, then takes one day
//   or month step per cycle in the run state, then the finish state loads the output
//   register: days take n steps, weeks 7n, months n, year style adds and invalid dates
//   no run steps. the next word is taken once the sequencer is idle again. the worst
//   case is 1023 weeks, 7161 day steps, all made by the single shared step unit.
//   the leap flag is registered from the next year, so it always matches the date.
// reset
//   rst_n clears the sequencer and the output valid; no word is pending after.
// stall
//   the finished result sits in an output register; a new word is accepted while
//   it waits, and the next result is held in the sequencer until m_axis_tready.
`default_nettype none

module gregorian_date_adder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // amount[9:0], start_day[14:10], start_month[18:15], start_year[33:19], zero fill
    input  wire logic [39:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // day[4:0], month[8:5], year[23:9]
    output logic [23:0]      m_axis_tdata,
    // overflow[0], invalid[1]
    output logic [1:0]       m_axis_tuser
);

    gda_pkg::state_t                    state_reg, state_next;
    gda_pkg::date_t                     date_reg, date_next;
    logic [gda_pkg::FUNC_W-1:0]         func_reg, func_next;
    logic [gda_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [gda_pkg::ADDEND_W-1:0]       addend_reg, addend_next;
    logic                               ovf_reg, ovf_next;
    logic                               inv_reg, inv_next;
    logic                               leap_reg;
    logic                               out_valid_reg, out_valid_next;
    gda_pkg::date_t                     out_date_reg, out_date_next;
    logic                               out_ovf_reg, out_ovf_next;
    logic                               out_inv_reg, out_inv_next;

    gda_pkg::step_ctrl_t                ctrl;
    gda_pkg::date_t                     step_date;
    logic                               step_ovf;

    logic [gda_pkg::AMOUNT_W-1:0]       in_amount;
    logic [gda_pkg::DAY_W-1:0]          len_check;
    logic                               in_accept;
    logic                               out_accept;

    assign in_amount  = s_axis_tdata[9:0];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = out_valid_reg && m_axis_tready;

    gda_step u_step (
        .ctrl   (ctrl),
        .cur    (date_reg),
        .addend (addend_reg),
        .nxt    (step_date),
        .ovf    (step_ovf)
    );

    always_comb
    begin
        state_next     = state_reg;
        date_next      = date_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        addend_next    = addend_reg;
        ovf_next       = ovf_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg;
        out_date_next  = out_date_reg;
        out_ovf_next   = out_ovf_reg;
        out_inv_next   = out_inv_reg;
        s_axis_tready  = 1'b0;
        len_check      = gda_pkg::days_in(date_reg.month, leap_reg);
        ctrl.leap      = leap_reg;
        ctrl.op        = gda_pkg::OP_YEARS;

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    date_next.day   = s_axis_tdata[14:10];
                    date_next.month = s_axis_tdata[18:15];
                    date_next.year  = s_axis_tdata[33:19];
                    func_next       = s_axis_tuser;
                    ovf_next        = 1'b0;
                    inv_next        = 1'b0;
                    count_next      = {3'd0, in_amount};
                    addend_next     = {4'd0, in_amount};
                    case (s_axis_tuser)
                        gda_pkg::FUNC_WEEKS:
                        begin
                            count_next = ({3'd0, in_amount} << 3) - {3'd0, in_amount};
                        end
                        gda_pkg::FUNC_DECADES:
                        begin
                            addend_next = ({4'd0, in_amount} << 3) + ({4'd0, in_amount} << 1);
                        end
                        gda_pkg::FUNC_CENTURY:
                        begin
                            addend_next = gda_pkg::ADD_CENTURY;
                        end
                        gda_pkg::FUNC_MILLENNIUM:
                        begin
                            addend_next = gda_pkg::ADD_MILLENIA;
                        end
                        default:
                        begin
                            addend_next = {4'd0, in_amount};
                        end
                    endcase
                    state_next = gda_pkg::ST_SETTLE;
                end
            end
            gda_pkg::ST_SETTLE:
            begin
                state_next = gda_pkg::ST_CHECK;
            end
            gda_pkg::ST_CHECK:
            begin
                if (date_reg.month == '0 || date_reg.month > gda_pkg::MONTH_DEC
                    || date_reg.day == '0 || date_reg.day > len_check)
                begin
                    inv_next   = 1'b1;
                    state_next = gda_pkg::ST_FINISH;
                end
                else
                begin
                    case (func_reg)
                        gda_pkg::FUNC_DAYS, gda_pkg::FUNC_WEEKS, gda_pkg::FUNC_MONTHS:
                        begin
                            state_next = (count_reg == '0) ? gda_pkg::ST_FINISH
                                                           : gda_pkg::ST_RUN;
                        end
                        gda_pkg::FUNC_YEARS, gda_pkg::FUNC_DECADES,
                        gda_pkg::FUNC_CENTURY, gda_pkg::FUNC_MILLENNIUM:
                        begin
                            date_next  = step_date;
                            ovf_next   = step_ovf;
                            state_next = gda_pkg::ST_FINISH;
                        end
                        default:
                        begin
                            state_next = gda_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            gda_pkg::ST_RUN:
            begin
                ctrl.op    = (func_reg == gda_pkg::FUNC_MONTHS) ? gda_pkg::OP_MONTH
                                                                : gda_pkg::OP_DAY;
                date_next  = step_date;
                ovf_next   = ovf_reg || step_ovf;
                count_next = count_reg - 13'd1;
                if (count_reg == 13'd1)
                begin
                    state_next = gda_pkg::ST_FINISH;
                end
            end
            gda_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_date_next  = date_reg;
                    out_ovf_next   = ovf_reg;
                    out_inv_next   = inv_reg;
                    state_next     = gda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg     <= date_next;
        func_reg     <= func_next;
        count_reg    <= count_next;
        addend_reg   <= addend_next;
        ovf_reg      <= ovf_next;
        inv_reg      <= inv_next;
        leap_reg     <= gda_pkg::leap_year(date_next.year);
        out_date_reg <= out_date_next;
        out_ovf_reg  <= out_ovf_next;
        out_inv_reg  <= out_inv_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_date_reg.year, out_date_reg.month, out_date_reg.day};
    assign m_axis_tuser  = {out_inv_reg, out_ovf_reg};

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gda_pkg::ST_RUN |-> count_reg != '0)
        else $error("step sequencer running with zero count");

    a_accept_settle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == gda_pkg::ST_SETTLE)
        else $error("accepted word did not start the sequencer");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("overflow and invalid both set");

    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |->
            m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] != 4'd0
            && m_axis_tdata[8:5] <= gda_pkg::MONTH_DEC)
        else $error("valid input produced an impossible date");

endmodule

`default_nettype wire
